/* hw/rtl/askc_pkg.sv */
// Shared constants for the alphabet shift keystream cipher.
// Field widths, operation codes and register indexes used by the top level.
// No dependencies.
`timescale 1ns / 1ps

package askc_pkg;

  // Default depth of the alphabet store.
  localparam int ALPHABET_DEPTH_DEF = 64;

  // Input and output field widths.
  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int KEY_W  = 6;
  localparam int POS_W  = 6;
  localparam int SIZE_W = 7;

  // Packed stream widths, padded to whole bytes.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic CFG_REG_SIZE = 1'b0;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd52;

  // Operation codes carried in in_tuser.
  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ENC  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEC  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_PASS = 2'd3;

endpackage

/* hw/rtl/alphabet_shift_keystream_cipher.sv */
// Top level of the alphabet shift keystream cipher.
// Holds the alphabet store, the search sequencer and the key reduction unit.
// Depends on askc_pkg.
`timescale 1ns / 1ps

// Usage
// The input stream carries one item per byte. in_tuser holds the operation:
// load an alphabet entry, encrypt, decrypt, or pass through. Load items write
// the character into the alphabet store at entry_position and echo it back.
// Text items are searched in the store, entry 0 upward, over the first
// alphabet_size entries (at most the store depth); a hit is shifted by the
// key value modulo that count and replaced by the character at the new
// position (out_tuser = 1). A miss leaves the byte unchanged (out_tuser = 0).
// The store is read once per cycle, so one item is in work at a time.
// Load and pass-through items go from acceptance straight to the finish
// state. A text item with active entries is searched one entry per cycle; a
// miss finishes after the last active entry, and a hit waits in the calc
// state for the six-step key remainder unit, which starts at acceptance,
// then reads the shifted position and finishes. out_tvalid rises once a
// finished item finds the output register free.
// The result waits in an output register; when the receiver stalls, the
// next item is still accepted and stops only before writing its result.
// Reset sets alphabet_size to 52 and empties the pipeline; the store keeps
// no defined value until loaded. Write alphabet_size only while idle.

module alphabet_shift_keystream_cipher #(
  parameter int ALPHABET_DEPTH = askc_pkg::ALPHABET_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input item stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: char_code [7:0], key_value [13:8], entry_position [19:14], zero
  input  logic [askc_pkg::IN_DATA_W-1:0]    in_tdata,
  // tuser: func [1:0]
  input  logic [askc_pkg::FUNC_W-1:0]       in_tuser,
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: out_char [7:0]
  output logic [askc_pkg::OUT_DATA_W-1:0]   out_tdata,
  // tuser: key_used [0]
  output logic                              out_tuser,
  // Configuration port.
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [askc_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [askc_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [askc_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  localparam int AW  = $clog2(ALPHABET_DEPTH);
  localparam int CW  = $clog2(ALPHABET_DEPTH + 1);
  localparam int MCW = $clog2(askc_pkg::KEY_W + 1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SRCH   = 3'd1;
  localparam logic [2:0] ST_CALC   = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]                       state_r, state_nxt;
  logic [askc_pkg::SIZE_W-1:0]      size_r;
  logic [askc_pkg::FUNC_W-1:0]      func_r;
  logic [askc_pkg::CHAR_W-1:0]      ch_r;
  logic [CW-1:0]                    n_r;
  logic [AW-1:0]                    cmp_idx_r;
  logic [AW-1:0]                    at_r;
  logic [CW-1:0]                    rem_r;
  logic [askc_pkg::KEY_W-1:0]       key_sh_r;
  logic [MCW-1:0]                   mod_cnt_r;
  logic [askc_pkg::CHAR_W-1:0]      res_char_r;
  logic                             res_used_r;
  logic                             out_valid_r;
  logic [askc_pkg::CHAR_W-1:0]      out_char_r;
  logic                             out_used_r;

  logic [askc_pkg::CHAR_W-1:0]      mem [ALPHABET_DEPTH];
  logic [askc_pkg::CHAR_W-1:0]      rd_data_r;
  logic [AW-1:0]                    rd_addr;

  logic [askc_pkg::CHAR_W-1:0]      in_char;
  logic [askc_pkg::KEY_W-1:0]       in_key;
  logic [askc_pkg::POS_W-1:0]       in_pos;
  logic                             in_acc;
  logic                             pos_ok;
  logic                             mem_we;
  logic [CW-1:0]                    n_act;
  logic                             out_free;
  logic                             cfg_wr;
  logic                             found;
  logic                             last_entry;
  logic [CW:0]                      mod_t;
  logic [CW-1:0]                    mod_nxt;
  logic [CW:0]                      sum_w;
  logic [CW:0]                      wrap_w;
  logic [AW-1:0]                    np;

  // Unpack the input item.
  assign in_char = in_tdata[7:0];
  assign in_key  = in_tdata[13:8];
  assign in_pos  = in_tdata[19:14];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign pos_ok    = (32'(in_pos) < 32'(ALPHABET_DEPTH));
  assign mem_we    = in_acc && (in_tuser == askc_pkg::FUNC_LOAD) && pos_ok;

  // Active entry count, saturated to the store depth.
  assign n_act = (32'(size_r) > 32'(ALPHABET_DEPTH)) ? CW'(ALPHABET_DEPTH) : CW'(size_r);

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == askc_pkg::CFG_REG_SIZE) ?
                      {{(askc_pkg::CFG_DATA_W - askc_pkg::SIZE_W){1'b0}}, size_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= askc_pkg::SIZE_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == askc_pkg::CFG_REG_SIZE)) begin
      size_r <= cfg_pwdata[askc_pkg::SIZE_W-1:0];
    end
  end

  // Search compare on the entry read last cycle.
  assign found      = (rd_data_r == ch_r);
  assign last_entry = (CW'(cmp_idx_r) == n_r - CW'(1));

  // One restoring step of key_value modulo n per cycle.
  always_comb begin
    mod_t   = {rem_r, key_sh_r[askc_pkg::KEY_W-1]};
    mod_nxt = (mod_t >= {1'b0, n_r}) ? CW'(mod_t - {1'b0, n_r}) : CW'(mod_t);
  end

  // New position: add or subtract the reduced key, then wrap once.
  always_comb begin
    if (func_r == askc_pkg::FUNC_ENC) begin
      sum_w = {1'b0, CW'(at_r)} + {1'b0, rem_r};
    end else begin
      sum_w = {1'b0, CW'(at_r)} + {1'b0, n_r} - {1'b0, rem_r};
    end
    wrap_w = (sum_w >= {1'b0, n_r}) ? (sum_w - {1'b0, n_r}) : sum_w;
    np     = AW'(wrap_w);
  end

  // Read address: entry 0 at acceptance, the next entry while searching,
  // and the shifted position once the remainder is known.
  always_comb begin
    unique case (state_r)
      ST_SRCH: rd_addr = cmp_idx_r + AW'(1);
      ST_CALC: rd_addr = np;
      default: rd_addr = '0;
    endcase
  end

  // Alphabet store: one write port, one registered read port. Writes come
  // only from load items, at acceptance. The port reads every cycle, but a
  // text item uses only reads made while no load writes, so a used read never meets a write.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(in_pos)] <= in_char;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (((in_tuser == askc_pkg::FUNC_ENC) || (in_tuser == askc_pkg::FUNC_DEC))
              && (n_act != '0)) begin
            state_nxt = ST_SRCH;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SRCH: begin
        if (found) begin
          state_nxt = ST_CALC;
        end else if (last_entry) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_CALC: begin
        if (mod_cnt_r == '0) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ:   state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mod_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        mod_cnt_r <= MCW'(askc_pkg::KEY_W);
      end else if (mod_cnt_r != '0) begin
        mod_cnt_r <= mod_cnt_r - MCW'(1);
      end
      if ((state_r == ST_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r     <= in_tuser;
      ch_r       <= in_char;
      n_r        <= n_act;
      cmp_idx_r  <= '0;
      rem_r      <= '0;
      key_sh_r   <= in_key;
      res_char_r <= in_char;
      res_used_r <= 1'b0;
    end else begin
      if (mod_cnt_r != '0) begin
        rem_r    <= mod_nxt;
        key_sh_r <= {key_sh_r[askc_pkg::KEY_W-2:0], 1'b0};
      end
      if (state_r == ST_SRCH) begin
        if (found) begin
          at_r <= cmp_idx_r;
        end else begin
          cmp_idx_r <= cmp_idx_r + AW'(1);
        end
      end
      if (state_r == ST_READ) begin
        res_char_r <= rd_data_r;
        res_used_r <= 1'b1;
      end
    end
    if ((state_r == ST_FINISH) && out_free) begin
      out_char_r <= res_char_r;
      out_used_r <= res_used_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tuser  = out_used_r;

  // The search never looks past the active entries.
  a_srch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH) |-> (CW'(cmp_idx_r) < n_r))
    else $error("search index beyond active alphabet");

  // Once the remainder is done, both it and the new position lie below n.
  a_calc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_CALC) && (mod_cnt_r == '0)) |-> ((rem_r < n_r) && (CW'(np) < n_r)))
    else $error("shifted position out of range");

  // A finished item whose slot is free shows up on the output next cycle.
  a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FINISH) && out_free) |=> (out_tvalid && in_tready))
    else $error("finished item not delivered");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the alphabet shift keystream cipher.
// Drives the item streams and the register port, and predicts every result itself.
// Depends on askc_pkg and alphabet_shift_keystream_cipher.
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH = askc_pkg::ALPHABET_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  // The slowest item is a hit at the last entry.
  localparam int SETTLE_CYCLES = DEPTH + 16;
  localparam int PRINT_CAP = 200;
  localparam int RANDOM_PER_PHASE = 152;
  localparam logic [askc_pkg::CFG_ADDR_W-1:0] SIZE_ADDR =
    askc_pkg::CFG_ADDR_W'(4 * int'(askc_pkg::CFG_REG_SIZE));

  typedef struct packed {
    logic [askc_pkg::CHAR_W-1:0] out_char;
    logic                        key_used;
  } cipher_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [askc_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [askc_pkg::FUNC_W-1:0]     in_tuser = askc_pkg::FUNC_PASS;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [askc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tuser;

  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [askc_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [askc_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [askc_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  // Predictor state: its own copy of the alphabet and of the size register.
  logic [askc_pkg::CHAR_W-1:0] alpha_mem [DEPTH];
  logic [askc_pkg::SIZE_W-1:0] alpha_size = askc_pkg::SIZE_RESET;
  cipher_out_t                 expected_chars [$];

  int   err_count = 0;
  int   cycle_count = 0;
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  logic hold_start = 1'b0;
  int   hold_left = 0;

  alphabet_shift_keystream_cipher u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit, far above the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Number of active entries; sizes above the store depth saturate.
  function automatic int active_entries();
    return (int'(alpha_size) > DEPTH) ? DEPTH : int'(alpha_size);
  endfunction

  // Works out the result of one accepted item and updates the alphabet copy.
  function automatic cipher_out_t predict_cipher(input logic [askc_pkg::FUNC_W-1:0] fn,
                                                 input logic [askc_pkg::CHAR_W-1:0] ch,
                                                 input logic [askc_pkg::KEY_W-1:0] key,
                                                 input logic [askc_pkg::POS_W-1:0] pos);
    cipher_out_t res;
    int n;
    int hit;
    int shift;
    int np;
    res.out_char = ch;
    res.key_used = 1'b0;
    hit = -1;
    case (fn)
      askc_pkg::FUNC_LOAD: begin
        alpha_mem[pos] = ch;
      end
      askc_pkg::FUNC_ENC, askc_pkg::FUNC_DEC: begin
        n = active_entries();
        // Search downward so that the lowest matching position wins.
        for (int i = n - 1; i >= 0; i--)
          if (alpha_mem[i] == ch) hit = i;
        if (hit >= 0) begin
          shift = int'(key) % n;
          if (fn == askc_pkg::FUNC_ENC) np = (hit + shift) % n;
          else np = (hit + n - shift) % n;
          res.out_char = alpha_mem[np];
          res.key_used = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("mismatch at %0t: %s got %0h, wanted %0h", $time, what, got, want);
  endtask

  // Compares one accepted result with the oldest prediction.
  task automatic check_cipher_result(input logic [askc_pkg::CHAR_W-1:0] got_char,
                                     input logic got_used);
    cipher_out_t want;
    if (expected_chars.size() == 0) begin
      report_mismatch("unexpected item, out_char", 32'(got_char), '0);
      return;
    end
    want = expected_chars.pop_front();
    if (got_char !== want.out_char)
      report_mismatch("out_char", 32'(got_char), 32'(want.out_char));
    if (got_used !== want.key_used)
      report_mismatch("key_used", 32'(got_used), 32'(want.key_used));
  endtask

  // Long receiver hold-off, counted down in cycles.
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result side: checks each accepted item and drives random or held-off stalls.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_cipher_result(out_tdata, out_tuser);
    if (hold_start || (hold_left != 0)) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Offers one item, with optional idle cycles first, and records its result.
  task automatic send_item(input logic [askc_pkg::FUNC_W-1:0] fn,
                           input logic [askc_pkg::CHAR_W-1:0] ch,
                           input logic [askc_pkg::KEY_W-1:0] key,
                           input logic [askc_pkg::POS_W-1:0] pos);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= fn;
    in_tdata <= {{(askc_pkg::IN_DATA_W - askc_pkg::CHAR_W - askc_pkg::KEY_W
                   - askc_pkg::POS_W){1'b0}}, pos, key, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_chars.insert(expected_chars.size(), predict_cipher(fn, ch, key, pos));
  endtask

  // Lets every pending item come back and the block settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register access: setup cycle, then access cycle until pready.
  task automatic cfg_access(input logic wr, input logic [askc_pkg::CFG_DATA_W-1:0] wdata,
                            output logic [askc_pkg::CFG_DATA_W-1:0] rdata);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= SIZE_ADDR;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Reads the size register back and compares it with the predictor copy.
  task automatic check_size_readback();
    logic [askc_pkg::CFG_DATA_W-1:0] rd;
    cfg_access(1'b0, '0, rd);
    if (rd !== askc_pkg::CFG_DATA_W'(alpha_size))
      report_mismatch("alphabet_size readback", rd, askc_pkg::CFG_DATA_W'(alpha_size));
  endtask

  task automatic write_size(input int value);
    logic [askc_pkg::CFG_DATA_W-1:0] rd;
    wait_idle();
    cfg_access(1'b1, askc_pkg::CFG_DATA_W'(value), rd);
    alpha_size = askc_pkg::SIZE_W'(value);
    check_size_readback();
  endtask

  // Mostly text drawn from the active alphabet, plus loads, misses and pass items.
  task automatic random_items(input int count);
    int r;
    int n;
    logic [askc_pkg::FUNC_W-1:0] fn;
    logic [askc_pkg::CHAR_W-1:0] ch;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      n = active_entries();
      ch = askc_pkg::CHAR_W'($urandom_range(255));
      if (r < 10) begin
        fn = askc_pkg::FUNC_LOAD;
      end else if (r < 15) begin
        fn = askc_pkg::FUNC_PASS;
      end else begin
        fn = $urandom_range(1) ? askc_pkg::FUNC_ENC : askc_pkg::FUNC_DEC;
        if (n > 0 && $urandom_range(99) < 80) ch = alpha_mem[$urandom_range(n - 1)];
      end
      send_item(fn, ch, askc_pkg::KEY_W'($urandom_range(63)),
                askc_pkg::POS_W'($urandom_range(63)));
    end
  endtask

  task automatic test_reset_value();
    check_size_readback();
  endtask

  // Small alphabet with a duplicate entry and the extreme byte codes.
  task automatic test_directed_shifts();
    tx_idle_pct = 14;
    rx_stall_pct = 14;
    write_size(8);
    send_item(askc_pkg::FUNC_LOAD, 8'h41, 6'd0, 6'd0);
    send_item(askc_pkg::FUNC_LOAD, 8'h00, 6'd63, 6'd1);
    send_item(askc_pkg::FUNC_LOAD, 8'h43, 6'd0, 6'd2);
    send_item(askc_pkg::FUNC_LOAD, 8'hFF, 6'd0, 6'd3);
    send_item(askc_pkg::FUNC_LOAD, 8'h45, 6'd0, 6'd4);
    send_item(askc_pkg::FUNC_LOAD, 8'h41, 6'd0, 6'd5);
    send_item(askc_pkg::FUNC_LOAD, 8'h47, 6'd0, 6'd6);
    send_item(askc_pkg::FUNC_LOAD, 8'h48, 6'd0, 6'd7);
    // Duplicate character resolves to its lowest position.
    send_item(askc_pkg::FUNC_ENC, 8'h41, 6'd0, 6'd63);
    send_item(askc_pkg::FUNC_ENC, 8'h41, 6'd1, 6'd0);
    // Wrap past the top and below zero.
    send_item(askc_pkg::FUNC_ENC, 8'h48, 6'd1, 6'd0);
    send_item(askc_pkg::FUNC_DEC, 8'h41, 6'd1, 6'd0);
    // Keys at or above the size are reduced first; smaller keys are also sent.
    send_item(askc_pkg::FUNC_ENC, 8'h43, 6'd63, 6'd0);
    send_item(askc_pkg::FUNC_DEC, 8'hFF, 6'd63, 6'd0);
    send_item(askc_pkg::FUNC_ENC, 8'h00, 6'd5, 6'd0);
    send_item(askc_pkg::FUNC_DEC, 8'h47, 6'd0, 6'd0);
    // A byte outside the alphabet and pass-through items come back unchanged.
    send_item(askc_pkg::FUNC_ENC, 8'h20, 6'd3, 6'd0);
    send_item(askc_pkg::FUNC_PASS, 8'h41, 6'd5, 6'd0);
    send_item(askc_pkg::FUNC_PASS, 8'hFF, 6'd63, 6'd63);
    // Reload an active entry and write the last store position.
    send_item(askc_pkg::FUNC_LOAD, 8'h5A, 6'd63, 6'd7);
    send_item(askc_pkg::FUNC_LOAD, 8'h7E, 6'd0, 6'd63);
    send_item(askc_pkg::FUNC_ENC, 8'h5A, 6'd8, 6'd0);
    send_item(askc_pkg::FUNC_DEC, 8'h47, 6'd6, 6'd0);
  endtask

  // Size zero passes everything through; size one maps each hit to itself.
  task automatic test_size_edges();
    write_size(0);
    send_item(askc_pkg::FUNC_ENC, 8'h41, 6'd1, 6'd0);
    send_item(askc_pkg::FUNC_DEC, 8'hFF, 6'd63, 6'd0);
    write_size(1);
    send_item(askc_pkg::FUNC_ENC, 8'h41, 6'd63, 6'd0);
    send_item(askc_pkg::FUNC_DEC, 8'h00, 6'd2, 6'd0);
  endtask

  // Random phases over many sizes, cycling through the idling patterns.
  task automatic test_random_phases();
    int phase_sizes [12] = '{64, 1, 2, 127, 5, 52, 33, 100, 0, 64, 17, 65};
    int tx_modes [4] = '{0, 76, 0, 14};
    int rx_modes [4] = '{0, 0, 76, 14};
    for (int p = 0; p < 12; p++) begin
      write_size(phase_sizes[p]);
      tx_idle_pct = tx_modes[p % 4];
      rx_stall_pct = rx_modes[p % 4];
      // Fill the whole store first so that any later size reads loaded entries.
      if (p == 0)
        for (int e = 0; e < DEPTH; e++)
          send_item(askc_pkg::FUNC_LOAD, askc_pkg::CHAR_W'($urandom_range(255)),
                    askc_pkg::KEY_W'($urandom_range(63)), askc_pkg::POS_W'(e));
      random_items(RANDOM_PER_PHASE);
    end
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    write_size(64);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    fork
      begin
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      random_items(40);
    join
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_value();
    test_directed_shifts();
    test_size_edges();
    test_random_phases();
    test_backpressure();
    wait_idle();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
